// File: sv/bpf_pkg.sv
package bpf_pkg;

  // Field widths
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam logic [CNT_W-1:0] POOL_DEPTH_RESET = 7'd64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE   = 2'd2;
  localparam logic [OP_W-1:0] OP_OPEN    = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_CLOSING = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_REJECT  = 2'd3;

  // Requests from the control logic to the ring and mark stores
  typedef struct packed {
    logic             clear;
    logic             ring_re;
    logic [IDX_W-1:0] ring_raddr;
    logic             ring_we;
    logic [IDX_W-1:0] ring_waddr;
    logic [IDX_W-1:0] ring_wdata;
    logic             mark_re;
    logic [IDX_W-1:0] mark_raddr;
    logic             mark_we;
    logic [IDX_W-1:0] mark_waddr;
    logic             mark_wdata;
  } bpf_mem_req_t;

  // Registered read data, already resolved against the valid bits
  typedef struct packed {
    logic [IDX_W-1:0] ring_data;
    logic             mark_data;
  } bpf_mem_rsp_t;

  // Depth taken at open: zero selects the reset depth, then saturate to capacity
  function automatic logic [CNT_W-1:0] clamp_depth(input logic [CNT_W-1:0] d,
                                                   input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] r;
    r = (d == '0) ? POOL_DEPTH_RESET : d;
    if (r > cap) r = cap;
    return r;
  endfunction

endpackage

// File: sv/block_pool_free_ring_top.sv
// Flow: each request walks ring read, mark read and commit; the mark read of an acquire needs
// the block index that the registered ring read returns. The result beat is registered at the
// commit, which waits while an earlier beat is still held; no new request is taken until the
// current one commits.
// Reset: synchronous, active low; the pool comes up open at its full capacity with every
// block free, and both stores are cleared at once through per-entry valid bits (no sweep).
module block_pool_free_ring_top #(
  parameter int MAX_BLOCKS = bpf_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bpf_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bpf_pkg::OP_W-1:0]  in_operation,
  input  logic [bpf_pkg::IDX_W-1:0] in_block_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bpf_pkg::ST_W-1:0]  out_status,
  output logic [bpf_pkg::IDX_W-1:0] out_granted_index,
  output logic [bpf_pkg::CNT_W-1:0] out_free_blocks,
  output logic [bpf_pkg::CNT_W-1:0] out_blocks_out
);
  import bpf_pkg::*;

  localparam int RING_CAP = (MAX_BLOCKS < (1 << IDX_W)) ? MAX_BLOCKS : (1 << IDX_W);
  localparam int AW       = $clog2(RING_CAP);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(RING_CAP);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [OP_W-1:0]  op_r;
  logic [IDX_W-1:0] blk_r;
  logic [CNT_W-1:0] pool_depth_r;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] outc_r, outc_nxt;
  logic             closing_r, closing_nxt;

  logic             out_valid_r;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic [IDX_W-1:0] granted_r, granted_nxt;
  logic [CNT_W-1:0] free_out_r;
  logic [CNT_W-1:0] outc_out_r;

  bpf_mem_req_t req;
  bpf_mem_rsp_t rsp;
  logic         accept;
  logic         fire;
  logic [IDX_W-1:0] b;

  bpf_store #(.DEPTH(RING_CAP)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign b        = rsp.ring_data;

  // Sequence reads, decide and commit
  always_comb begin
    state_nxt   = state_r;
    depth_nxt   = depth_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    free_nxt    = free_r;
    outc_nxt    = outc_r;
    closing_nxt = closing_r;
    status_nxt  = ST_OK;
    granted_nxt = '0;
    req         = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req.ring_re    = 1'b1;
          req.ring_raddr = IDX_W'(head_r);
          state_nxt      = S_RD1;
        end
      end
      S_RD1: begin
        req.mark_re    = 1'b1;
        req.mark_raddr = (op_r == OP_ACQUIRE) ? b : blk_r;
        state_nxt      = S_EXEC;
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
          case (op_r)
            OP_ACQUIRE: begin
              if (closing_r) begin
                status_nxt = ST_CLOSING;
              end else if (free_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if ({1'b0, b} >= depth_r || rsp.mark_data) begin
                status_nxt = ST_REJECT;
              end else begin
                if (CNT_W'(head_r) + 7'd1 == depth_r) head_nxt = '0;
                else head_nxt = head_r + 1'b1;
                free_nxt        = free_r - 7'd1;
                outc_nxt        = outc_r + 7'd1;
                req.mark_we     = 1'b1;
                req.mark_waddr  = b;
                req.mark_wdata  = 1'b1;
                granted_nxt     = b;
              end
            end
            OP_RELEASE: begin
              if (closing_r) begin
                status_nxt = ST_CLOSING;
              end else if ({1'b0, blk_r} >= depth_r || !rsp.mark_data || outc_r == '0) begin
                status_nxt = ST_REJECT;
              end else begin
                req.mark_we    = 1'b1;
                req.mark_waddr = blk_r;
                req.mark_wdata = 1'b0;
                outc_nxt       = outc_r - 7'd1;
                if (free_r < depth_r) begin
                  req.ring_we    = 1'b1;
                  req.ring_waddr = IDX_W'(tail_r);
                  req.ring_wdata = blk_r;
                  if (CNT_W'(tail_r) + 7'd1 == depth_r) tail_nxt = '0;
                  else tail_nxt = tail_r + 1'b1;
                  free_nxt = free_r + 7'd1;
                end
              end
            end
            OP_CLOSE: begin
              closing_nxt = 1'b1;
            end
            OP_OPEN: begin
              depth_nxt   = clamp_depth(pool_depth_r, CAP);
              req.clear   = 1'b1;
              head_nxt    = '0;
              tail_nxt    = '0;
              free_nxt    = clamp_depth(pool_depth_r, CAP);
              outc_nxt    = '0;
              closing_nxt = 1'b0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and pool state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pool_depth_r <= POOL_DEPTH_RESET;
      depth_r      <= clamp_depth(POOL_DEPTH_RESET, CAP);
      head_r       <= '0;
      tail_r       <= '0;
      free_r       <= clamp_depth(POOL_DEPTH_RESET, CAP);
      outc_r       <= '0;
      closing_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      depth_r   <= depth_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      free_r    <= free_nxt;
      outc_r    <= outc_nxt;
      closing_r <= closing_nxt;
      if (cfg_we) pool_depth_r <= cfg_wdata;
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Hold the request fields and the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      blk_r <= in_block_index;
    end
    if (fire) begin
      status_r   <= status_nxt;
      granted_r  <= granted_nxt;
      free_out_r <= free_nxt;
      outc_out_r <= outc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_index = granted_r;
  assign out_free_blocks   = free_out_r;
  assign out_blocks_out    = outc_out_r;

  // Free and checked-out blocks always add up to the depth in force
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, free_r} + {1'b0, outc_r}) == {1'b0, depth_r})
    else $error("free and checked-out counts do not add up to the depth");

  // Ring pointers stay inside the pool
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(head_r) < depth_r) && (CNT_W'(tail_r) < depth_r))
    else $error("ring pointer beyond the pool depth");

  // A result beat only appears out of the commit step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EXEC)
    else $error("result beat raised outside the commit step");

  // A granted index other than zero only comes with an ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && granted_r != '0) |-> status_r == ST_OK)
    else $error("granted index without ok status");

endmodule

// File: sv/bpf_store.sv
module bpf_store #(
  parameter int DEPTH = bpf_pkg::MAX_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpf_pkg::bpf_mem_req_t req,
  output bpf_pkg::bpf_mem_rsp_t rsp
);
  import bpf_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [IDX_W-1:0] ring_mem [DEPTH];
  logic             mark_mem [DEPTH];
  logic [DEPTH-1:0] ring_vld_r;
  logic [DEPTH-1:0] mark_vld_r;

  logic [IDX_W-1:0] ring_q_r;
  logic             ring_qv_r;
  logic [AW-1:0]    ring_qa_r;
  logic             mark_q_r;
  logic             mark_qv_r;

  // Track written entries; an open drops them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      mark_vld_r <= '0;
    end else if (req.clear) begin
      ring_vld_r <= '0;
      mark_vld_r <= '0;
    end else begin
      if (req.ring_we) ring_vld_r[req.ring_waddr[AW-1:0]] <= 1'b1;
      if (req.mark_we) mark_vld_r[req.mark_waddr[AW-1:0]] <= 1'b1;
    end
  end

  // Ring store: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.ring_we) ring_mem[req.ring_waddr[AW-1:0]] <= req.ring_wdata;
    if (req.ring_re) begin
      ring_q_r  <= ring_mem[req.ring_raddr[AW-1:0]];
      ring_qv_r <= ring_vld_r[req.ring_raddr[AW-1:0]];
      ring_qa_r <= req.ring_raddr[AW-1:0];
    end
  end

  // Mark store: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.mark_we) mark_mem[req.mark_waddr[AW-1:0]] <= req.mark_wdata;
    if (req.mark_re) begin
      mark_q_r  <= mark_mem[req.mark_raddr[AW-1:0]];
      mark_qv_r <= mark_vld_r[req.mark_raddr[AW-1:0]];
    end
  end

  // An unwritten ring entry holds its own position; an unwritten mark is free
  assign rsp.ring_data = ring_qv_r ? ring_q_r : IDX_W'(ring_qa_r);
  assign rsp.mark_data = mark_qv_r & mark_q_r;

endmodule

// File: tb/sv/block_pool_free_ring_top_tb.sv
module block_pool_free_ring_top_tb;
  import bpf_pkg::*;

  localparam int POOL_CAP     = 64;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_BEATS  = 600;
  localparam logic ROW_BEAT   = 1'b0;
  localparam logic ROW_CFG    = 1'b1;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] free_blocks;
    logic [CNT_W-1:0] blocks_out;
  } pool_result_t;

  typedef struct packed {
    logic             kind;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] blk;
    logic [CNT_W-1:0] depth;
    logic             typed;
    pool_result_t     res;
  } pool_row_t;

  // Directed sequence: starts from the reset depth of 64
  localparam int DIR_ROWS = 25;
  localparam pool_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_BEAT, OP_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0, 7'd63, 7'd1}},
    '{ROW_BEAT, OP_ACQUIRE, 6'd63, 7'd0,   1'b1, '{ST_OK,      6'd1, 7'd62, 7'd2}},
    '{ROW_BEAT, OP_RELEASE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0, 7'd63, 7'd1}},
    '{ROW_BEAT, OP_RELEASE, 6'd0,  7'd0,   1'b1, '{ST_REJECT,  6'd0, 7'd63, 7'd1}},
    '{ROW_BEAT, OP_RELEASE, 6'd63, 7'd0,   1'b1, '{ST_REJECT,  6'd0, 7'd63, 7'd1}},
    '{ROW_BEAT, OP_RELEASE, 6'd1,  7'd0,   1'b1, '{ST_OK,      6'd0, 7'd64, 7'd0}},
    '{ROW_BEAT, OP_RELEASE, 6'd1,  7'd0,   1'b1, '{ST_REJECT,  6'd0, 7'd64, 7'd0}},
    '{ROW_BEAT, OP_ACQUIRE, 6'd0,  7'd0,   1'b0, '{ST_OK,      6'd0, 7'd0,  7'd0}},
    '{ROW_BEAT, OP_CLOSE,   6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0, 7'd63, 7'd1}},
    '{ROW_BEAT, OP_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_CLOSING, 6'd0, 7'd63, 7'd1}},
    '{ROW_BEAT, OP_RELEASE, 6'd2,  7'd0,   1'b1, '{ST_CLOSING, 6'd0, 7'd63, 7'd1}},
    '{ROW_BEAT, OP_CLOSE,   6'd42, 7'd0,   1'b1, '{ST_OK,      6'd0, 7'd63, 7'd1}},
    '{ROW_BEAT, OP_OPEN,    6'd21, 7'd0,   1'b1, '{ST_OK,      6'd0, 7'd64, 7'd0}},
    '{ROW_CFG,  OP_OPEN,    6'd0,  7'd1,   1'b0, '{ST_OK,      6'd0, 7'd0,  7'd0}},
    '{ROW_BEAT, OP_OPEN,    6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0, 7'd1,  7'd0}},
    '{ROW_BEAT, OP_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0, 7'd0,  7'd1}},
    '{ROW_BEAT, OP_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_EMPTY,   6'd0, 7'd0,  7'd1}},
    '{ROW_BEAT, OP_RELEASE, 6'd1,  7'd0,   1'b1, '{ST_REJECT,  6'd0, 7'd0,  7'd1}},
    '{ROW_BEAT, OP_RELEASE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0, 7'd1,  7'd0}},
    '{ROW_CFG,  OP_OPEN,    6'd0,  7'd0,   1'b0, '{ST_OK,      6'd0, 7'd0,  7'd0}},
    '{ROW_BEAT, OP_OPEN,    6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0, 7'd64, 7'd0}},
    '{ROW_CFG,  OP_OPEN,    6'd0,  7'd127, 1'b0, '{ST_OK,      6'd0, 7'd0,  7'd0}},
    '{ROW_BEAT, OP_ACQUIRE, 6'd0,  7'd0,   1'b0, '{ST_OK,      6'd0, 7'd0,  7'd0}},
    '{ROW_BEAT, OP_OPEN,    6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0, 7'd64, 7'd0}},
    '{ROW_BEAT, OP_RELEASE, 6'd63, 7'd0,   1'b1, '{ST_REJECT,  6'd0, 7'd64, 7'd0}}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_operation;
  logic [IDX_W-1:0] in_block_index;
  logic             out_valid;
  logic             out_ready;
  logic [ST_W-1:0]  out_status;
  logic [IDX_W-1:0] out_granted_index;
  logic [CNT_W-1:0] out_free_blocks;
  logic [CNT_W-1:0] out_blocks_out;

  // Pool shadow state
  int               ring_slot [POOL_CAP];
  bit               held_mark [POOL_CAP];
  int               head_ptr;
  int               tail_ptr;
  int               free_cnt;
  int               held_cnt;
  bit               closing;
  logic [CNT_W-1:0] depth_reg;
  int               depth_live;

  pool_result_t     pending_results [$];
  int               snd_idle_pct;
  int               rcv_idle_pct;
  int               fail_count;
  int               request_count;
  int               depth_changes;
  int               empty_seen;
  int               closing_seen;
  int               reject_seen;
  int               quiet_cycles;

  block_pool_free_ring_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_block_index    (in_block_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_blocks   (out_free_blocks),
    .out_blocks_out    (out_blocks_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Reload the pool at the depth held in the register
  function automatic void reopen_pool();
    depth_live = (depth_reg == '0) ? 64 : int'(depth_reg);
    if (depth_live > POOL_CAP) depth_live = POOL_CAP;
    for (int i = 0; i < POOL_CAP; i++) begin
      ring_slot[i] = i;
      held_mark[i] = 1'b0;
    end
    head_ptr = 0;
    tail_ptr = 0;
    free_cnt = depth_live;
    held_cnt = 0;
    closing  = 1'b0;
  endfunction

  // Apply one request to the shadow pool and return the result it yields
  function automatic pool_result_t pool_apply(logic [OP_W-1:0] op, logic [IDX_W-1:0] blk);
    pool_result_t r;
    int           b;
    r.status  = ST_OK;
    r.granted = '0;
    case (op)
      OP_ACQUIRE: begin
        if (closing) begin
          r.status = ST_CLOSING;
        end else if (free_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          b = ring_slot[head_ptr];
          if (b >= depth_live || held_mark[b]) begin
            r.status = ST_REJECT;
          end else begin
            head_ptr     = (head_ptr + 1) % depth_live;
            free_cnt     = free_cnt - 1;
            held_mark[b] = 1'b1;
            held_cnt     = held_cnt + 1;
            r.granted    = b[IDX_W-1:0];
          end
        end
      end
      OP_RELEASE: begin
        if (closing) begin
          r.status = ST_CLOSING;
        end else if (int'(blk) >= depth_live || !held_mark[blk] || held_cnt == 0) begin
          r.status = ST_REJECT;
        end else begin
          held_mark[blk] = 1'b0;
          held_cnt       = held_cnt - 1;
          // A full ring only drops the mark
          if (free_cnt < depth_live) begin
            ring_slot[tail_ptr] = int'(blk);
            tail_ptr            = (tail_ptr + 1) % depth_live;
            free_cnt            = free_cnt + 1;
          end
        end
      end
      OP_CLOSE: closing = 1'b1;
      default:  reopen_pool();
    endcase
    r.free_blocks = free_cnt[CNT_W-1:0];
    r.blocks_out  = held_cnt[CNT_W-1:0];
    return r;
  endfunction

  // Pick a request that mostly keeps the pool in a sensible flow
  function automatic void pick_request(output logic [OP_W-1:0] op, output logic [IDX_W-1:0] blk);
    int roll;
    int nth;
    roll = $urandom_range(99);
    blk  = IDX_W'($urandom_range(63));
    if (closing) begin
      op = (roll < 70) ? OP_OPEN : OP_W'($urandom_range(3));
    end else if (roll < 45) begin
      op = OP_ACQUIRE;
    end else if (roll < 85) begin
      op = OP_ACQUIRE;
      if (held_cnt > 0) begin
        op  = OP_RELEASE;
        nth = $urandom_range(held_cnt - 1);
        for (int i = 0; i < POOL_CAP; i++) begin
          if (held_mark[i]) begin
            if (nth == 0) blk = IDX_W'(i);
            nth = nth - 1;
          end
        end
      end
    end else if (roll < 92) begin
      op = OP_RELEASE;
    end else if (roll < 96) begin
      op = OP_CLOSE;
    end else begin
      op = OP_OPEN;
    end
  endfunction

  // Offer one beat, hold it until taken, then log what it should return
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] blk,
                              input bit typed, input pool_result_t typed_res);
    pool_result_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_block_index <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = pool_apply(op, blk);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
    request_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_depth(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    depth_reg  = value;
    depth_changes++;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Check each result beat against the oldest outstanding prediction
  always @(posedge clk) begin : result_check
    pool_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d granted %0d", out_status,
               out_granted_index);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_granted_index != want.granted) begin
          $error("granted_index: expected %0d, got %0d", want.granted, out_granted_index);
          fail_count++;
        end
        if (out_free_blocks != want.free_blocks) begin
          $error("free_blocks: expected %0d, got %0d", want.free_blocks, out_free_blocks);
          fail_count++;
        end
        if (out_blocks_out != want.blocks_out) begin
          $error("blocks_out: expected %0d, got %0d", want.blocks_out, out_blocks_out);
          fail_count++;
        end
        if (want.status == ST_EMPTY)   empty_seen++;
        if (want.status == ST_CLOSING) closing_seen++;
        if (want.status == ST_REJECT)  reject_seen++;
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] blk;
    logic [CNT_W-1:0] depth;
    int               roll;
    int               seg;
    int               phase_beats;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_operation   = OP_ACQUIRE;
    in_block_index = '0;
    snd_idle_pct   = 28;
    rcv_idle_pct   = 73;
    request_count  = 0;
    depth_changes  = 0;
    depth_reg      = POOL_DEPTH_RESET;
    reopen_pool();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_drained();
        write_depth(DIRECTED[i].depth);
      end else begin
        send_request(DIRECTED[i].op, DIRECTED[i].blk, DIRECTED[i].typed, DIRECTED[i].res);
      end
    end

    // Random segments, each opened at a fresh depth
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 73 : 0;
      rcv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 28 : 0;
      phase_beats  = 0;
      while (phase_beats < PHASE_BEATS) begin
        roll = $urandom_range(99);
        if (roll < 50)      depth = CNT_W'($urandom_range(1, 8));
        else if (roll < 65) depth = 7'd64;
        else if (roll < 75) depth = '0;
        else if (roll < 85) depth = CNT_W'($urandom_range(65, 127));
        else                depth = CNT_W'($urandom_range(1, 127));
        wait_drained();
        write_depth(depth);
        send_request(OP_OPEN, IDX_W'($urandom_range(63)), 1'b0, '0);
        seg = $urandom_range(20, 60);
        repeat (seg) begin
          pick_request(op, blk);
          send_request(op, blk, 1'b0, '0);
        end
        phase_beats += seg + 1;
      end
    end

    // Drain, then let the pipeline settle
    wait_drained();
    repeat (4) @(negedge clk);
    $display("Run covered %0d requests over %0d depth settings and three idling patterns.",
             request_count, depth_changes);
    $display("Results seen: %0d empty, %0d closing, %0d rejected.", empty_seen,
             closing_seen, reject_seen);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
